@@ rtl/plcl_pkg.sv @@
// ----------------------------------------------------------------------------
// plcl_pkg
// Shared constants, codes and stage payload types of the piecewise-linear
// curve lookup.
// ----------------------------------------------------------------------------
package plcl_pkg;

  // table geometry
  localparam int NumCurves = 2;
  localparam int NumPoints = 8;

  // field widths
  localparam int CurveW = 1;
  localparam int PointW = 3;
  localparam int ValW   = 24;
  localparam int FracW  = 20;

  // fixed point: 16 fraction bits
  localparam int QBits = 16;
  localparam int QOne  = 1 << QBits;

  // derived widths
  localparam int IdxW  = $clog2(NumPoints);
  localparam int Depth = NumCurves * NumPoints;
  localparam int AddrW = $clog2(Depth);
  localparam int PosW  = FracW + IdxW;          // fraction * (points-1)
  localparam int SegW  = PosW - QBits + 1;      // segment number, room for +1
  localparam int WgtW  = QBits + 1;             // weight in [0, 1.0]
  localparam int MulW  = (ValW + 1) + (WgtW + 1);

  typedef enum logic {
    OpWrite = 1'b0,
    OpEval  = 1'b1
  } op_e;

  // index stage to table stage
  typedef struct packed {
    op_e                    op;
    logic                   wr_ok;
    logic                   curve_ok;
    logic [AddrW-1:0]       wr_addr;
    logic [AddrW-1:0]       lo_addr;
    logic [AddrW-1:0]       hi_addr;
    logic signed [ValW-1:0] value;
    logic [WgtW-1:0]        weight;
  } lookup_t;

  // table stage to blend stages
  typedef struct packed {
    logic signed [ValW-1:0] lo_val;
    logic signed [ValW-1:0] hi_val;
    logic [WgtW-1:0]        weight;
  } pair_t;

endpackage

@@ rtl/plcl_index.sv @@
// ----------------------------------------------------------------------------
// plcl_index
// Two stages: scale the position by the segment count, then find the
// bracketing points, the in-segment weight and the table addresses.
// ----------------------------------------------------------------------------
module plcl_index (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [0:0]                            operation_i,
  input  logic [plcl_pkg::CurveW-1:0]           curve_select_i,
  input  logic [plcl_pkg::PointW-1:0]           point_index_i,
  input  logic signed [plcl_pkg::ValW-1:0]      point_value_i,
  input  logic signed [plcl_pkg::FracW-1:0]     fraction_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output plcl_pkg::lookup_t                     item_o
);

  localparam int PosW  = plcl_pkg::PosW;
  localparam int SegW  = plcl_pkg::SegW;
  localparam int IdxW  = plcl_pkg::IdxW;
  localparam int AddrW = plcl_pkg::AddrW;
  localparam int QBits = plcl_pkg::QBits;
  localparam int WgtW  = plcl_pkg::WgtW;

  localparam logic signed [PosW-1:0] LastPos = PosW'(plcl_pkg::NumPoints - 1);
  localparam logic signed [SegW-1:0] LastSeg = SegW'(plcl_pkg::NumPoints - 1);
  localparam logic [IdxW-1:0]        LastIdx = IdxW'(plcl_pkg::NumPoints - 1);
  localparam logic [PosW:0]          QOneW   = (PosW + 1)'(plcl_pkg::QOne);

  function automatic logic [IdxW-1:0] clamp_idx(input logic signed [SegW-1:0] s);
    logic [IdxW-1:0] r;
    if (s[SegW-1]) begin
      r = '0;
    end else if (s > LastSeg) begin
      r = LastIdx;
    end else begin
      r = s[IdxW-1:0];
    end
    return r;
  endfunction

  // stage a registers
  logic                             va_q;
  plcl_pkg::op_e                    op_a_q;
  logic                             cok_a_q, wok_a_q;
  logic [AddrW-1:0]                 base_a_q;
  logic [plcl_pkg::PointW-1:0]      pidx_a_q;
  logic signed [plcl_pkg::ValW-1:0] value_a_q;
  logic signed [PosW-1:0]           pos_a_q;

  // stage a next values
  logic signed [PosW-1:0] frac_x;
  logic signed [PosW-1:0] pos_d;
  logic                   cok_d, wok_d;
  logic [AddrW-1:0]       base_d;

  // stage b
  logic                   vb_q;
  plcl_pkg::lookup_t      item_q, item_d;
  logic signed [SegW-1:0] seg_fl, seg, seg_up;
  logic [IdxW-1:0]        lo, hi;
  logic [PosW:0]          w_full;
  logic [WgtW-1:0]        weight;

  logic ready_a, ready_b;

  assign ready_b = ~vb_q | ready_i;
  assign ready_a = ~va_q | ready_b;
  assign ready_o = ready_a;
  assign valid_o = vb_q;
  assign item_o  = item_q;

  always_comb begin
    frac_x = PosW'(fraction_i);
    pos_d  = frac_x * LastPos;
    cok_d  = int'(curve_select_i) < plcl_pkg::NumCurves;
    wok_d  = cok_d && (int'(point_index_i) < plcl_pkg::NumPoints);
    base_d = AddrW'(int'(curve_select_i) * plcl_pkg::NumPoints);
  end

  // segment truncates toward zero, then both ends clamp to the grid
  always_comb begin
    seg_fl = SegW'(pos_a_q >>> QBits);
    if (pos_a_q[PosW-1] && (|pos_a_q[QBits-1:0])) begin
      seg = seg_fl + SegW'(1);
    end else begin
      seg = seg_fl;
    end
    seg_up = seg + SegW'(1);
    lo     = clamp_idx(seg);
    hi     = clamp_idx(seg_up);

    w_full = {pos_a_q[PosW-1], pos_a_q} - (PosW + 1)'({lo, {QBits{1'b0}}});
    if (w_full[PosW]) begin
      weight = '0;
    end else if (w_full > QOneW) begin
      weight = WgtW'(plcl_pkg::QOne);
    end else begin
      weight = w_full[WgtW-1:0];
    end

    item_d.op       = op_a_q;
    item_d.wr_ok    = wok_a_q;
    item_d.curve_ok = cok_a_q;
    item_d.wr_addr  = base_a_q + AddrW'(pidx_a_q);
    item_d.lo_addr  = base_a_q + AddrW'(lo);
    item_d.hi_addr  = base_a_q + AddrW'(hi);
    item_d.value    = value_a_q;
    item_d.weight   = weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      op_a_q    <= plcl_pkg::op_e'(operation_i);
      cok_a_q   <= cok_d;
      wok_a_q   <= wok_d;
      base_a_q  <= base_d;
      pidx_a_q  <= point_index_i;
      value_a_q <= point_value_i;
      pos_a_q   <= pos_d;
    end
    if (ready_b && va_q) begin
      item_q <= item_d;
    end
  end

endmodule

@@ rtl/plcl_table.sv @@
// ----------------------------------------------------------------------------
// plcl_table
// Point table: one write or two registered reads per transfer, with a
// valid bit per entry so unwritten points read as zero.
// ----------------------------------------------------------------------------
module plcl_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  plcl_pkg::lookup_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output plcl_pkg::pair_t   pair_o
);

  localparam int ValW  = plcl_pkg::ValW;
  localparam int Depth = plcl_pkg::Depth;

  logic [ValW-1:0]           mem_q [Depth];
  logic [Depth-1:0]          vld_q;
  logic                      vc_q;
  logic [ValW-1:0]           lo_q, hi_q;
  logic                      vld_lo_q, vld_hi_q, cok_q;
  logic [plcl_pkg::WgtW-1:0] weight_q;

  logic xfer, do_wr, do_rd;

  assign ready_o = ~vc_q | ready_i;
  assign xfer    = valid_i & ready_o;
  assign do_wr   = xfer && (item_i.op == plcl_pkg::OpWrite) && item_i.wr_ok;
  assign do_rd   = xfer && (item_i.op == plcl_pkg::OpEval);
  assign valid_o = vc_q;

  always_comb begin
    pair_o.lo_val = (vld_lo_q && cok_q) ? $signed(lo_q) : '0;
    pair_o.hi_val = (vld_hi_q && cok_q) ? $signed(hi_q) : '0;
    pair_o.weight = weight_q;
  end

  // write items leave the pipeline here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= 1'b0;
      vld_q <= '0;
    end else begin
      if (ready_o) begin
        vc_q <= valid_i && (item_i.op == plcl_pkg::OpEval);
      end
      if (do_wr) begin
        vld_q[item_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[item_i.wr_addr] <= item_i.value;
    end
    if (do_rd) begin
      lo_q     <= mem_q[item_i.lo_addr];
      hi_q     <= mem_q[item_i.hi_addr];
      vld_lo_q <= vld_q[item_i.lo_addr];
      vld_hi_q <= vld_q[item_i.hi_addr];
      cok_q    <= item_i.curve_ok;
      weight_q <= item_i.weight;
    end
  end

endmodule

@@ rtl/plcl_blend.sv @@
// ----------------------------------------------------------------------------
// plcl_blend
// Two stages: weighted difference of the bracketing points, then the
// rounded sum that forms the output register.
// ----------------------------------------------------------------------------
module plcl_blend (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  plcl_pkg::pair_t                  pair_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [plcl_pkg::ValW-1:0] curve_value_o
);

  localparam int ValW  = plcl_pkg::ValW;
  localparam int MulW  = plcl_pkg::MulW;
  localparam int QBits = plcl_pkg::QBits;

  localparam logic signed [MulW-1:0] Half = MulW'(plcl_pkg::QOne / 2);

  logic                   vd_q, ve_q;
  logic signed [ValW-1:0] lo_d_q;
  logic signed [MulW-1:0] prod_q, prod_d;
  logic signed [ValW-1:0] res_q, res_d;

  logic signed [ValW:0]   diff;
  logic signed [MulW-1:0] diff_x, wgt_x, sum;
  logic                   ready_d, ready_e;

  assign ready_e       = ~ve_q | ready_i;
  assign ready_d       = ~vd_q | ready_e;
  assign ready_o       = ready_d;
  assign valid_o       = ve_q;
  assign curve_value_o = res_q;

  always_comb begin
    diff   = (ValW + 1)'(pair_i.hi_val) - (ValW + 1)'(pair_i.lo_val);
    diff_x = MulW'(diff);
    wgt_x  = MulW'({1'b0, pair_i.weight});
    prod_d = diff_x * wgt_x;
  end

  // round to nearest, ties toward plus infinity
  always_comb begin
    sum   = prod_q + Half;
    res_d = lo_d_q + ValW'(sum >>> QBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ready_d) begin
        vd_q <= valid_i;
      end
      if (ready_e) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_d && valid_i) begin
      lo_d_q <= pair_i.lo_val;
      prod_q <= prod_d;
    end
    if (ready_e && vd_q) begin
      res_q <= res_d;
    end
  end

endmodule

@@ rtl/piecewise_linear_curve_lookup.sv @@
// pipeline: an evaluate result is registered in five register stages on its way
//   from the input transfer to the result output
// throughput: one item per cycle when not stalled; each stage holds one item and
//   moves on when the stage after it is empty or moving, so bubbles are squeezed
// write items update the point table in the third stage and produce no result
// reset: asynchronous, active low; clears all stage valids and the per-point
//   valid bits, so every point reads as zero until written
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup
// Uniform-grid linear interpolation over a small table of sampled curves.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_lookup (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [0:0]                            operation_i,
  input  logic [plcl_pkg::CurveW-1:0]           curve_select_i,
  input  logic [plcl_pkg::PointW-1:0]           point_index_i,
  input  logic signed [plcl_pkg::ValW-1:0]      point_value_i,
  input  logic signed [plcl_pkg::FracW-1:0]     fraction_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [plcl_pkg::ValW-1:0]      curve_value_o
);

  // index -> table
  logic              idx_valid, idx_ready;
  plcl_pkg::lookup_t idx_item;

  // table -> blend
  logic              tab_valid, tab_ready;
  plcl_pkg::pair_t   tab_pair;

  // stages 1-2: position scaling, segment search, clamping, addresses
  plcl_index u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .operation_i    (operation_i),
    .curve_select_i (curve_select_i),
    .point_index_i  (point_index_i),
    .point_value_i  (point_value_i),
    .fraction_i     (fraction_i),
    .valid_o        (idx_valid),
    .ready_i        (idx_ready),
    .item_o         (idx_item)
  );

  // stage 3: table write, or read of both bracketing points; writes and reads
  // happen in transfer order at this one stage, so a later evaluate always
  // sees every earlier write
  plcl_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (idx_valid),
    .ready_o (idx_ready),
    .item_i  (idx_item),
    .valid_o (tab_valid),
    .ready_i (tab_ready),
    .pair_o  (tab_pair)
  );

  // stages 4-5: multiply the difference by the weight, round and add
  plcl_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (tab_valid),
    .ready_o       (tab_ready),
    .pair_i        (tab_pair),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .curve_value_o (curve_value_o)
  );

endmodule
